[rtl/core/asv_pkg.sv]
// ----------------------------------------------------------------------------
// asv_pkg: shared types and constants for the ASCII sentence validator
// Character codes, header text, status codes and the hex digit helper.
// ----------------------------------------------------------------------------
package asv_pkg;

    localparam int unsigned BUFFER_LEN = 256;
    localparam int unsigned BODY_MAX   = BUFFER_LEN - 1;
    localparam int unsigned CNT_W      = $clog2(BUFFER_LEN);

    localparam logic [7:0] START_CHAR = 8'h24;  // '$'
    localparam logic [7:0] CR_CHAR    = 8'h0D;  // '\r'
    localparam logic [7:0] COMMA_CHAR = 8'h2C;  // ','

    localparam int unsigned HDR_LEN = 5;
    localparam logic [7:0] HDR_TEXT [HDR_LEN] = '{8'h56, 8'h4E, 8'h43, 8'h4D, 8'h56};  // VNCMV

    localparam logic [7:0] MIN_LENGTH_RST      = 8'd9;
    localparam logic [6:0] EXPECTED_FIELDS_RST = 7'd11;

    // configuration register indexes
    localparam logic CFG_MIN_LENGTH      = 1'b0;
    localparam logic CFG_EXPECTED_FIELDS = 1'b1;

    typedef enum logic [1:0] {
        ST_VALID      = 2'd0,
        ST_TOO_SHORT  = 2'd1,
        ST_CKSUM_BAD  = 2'd2,
        ST_HEADER_BAD = 2'd3
    } status_t;

    typedef struct packed {
        logic       overflowed;
        logic [7:0] computed_sum;
        logic [7:0] body_length;
        status_t    status;
    } verdict_t;

    // uppercase ASCII hex digit for one nibble
    function automatic logic [7:0] hex_char(input logic [3:0] nib);
        logic [7:0] res;
        if (nib < 4'd10) begin
            res = 8'h30 + {4'd0, nib};
        end else begin
            res = 8'h41 + {4'd0, nib} - 8'd10;
        end
        return res;
    endfunction

endpackage

[rtl/core/ascii_sentence_validator.sv]
// A verdict appears on m_tdata in the cycle after the beat that ends the body.
// Throughput: one byte per cycle; s_tready drops only while a verdict waits on the
// output register and m_tready is low.
// The per-byte state update and the verdict logic are computed in the same cycle.
// Reset (aresetn, synchronous, active low): hunting for '$', config back to
// min_length 9 and expected_fields 11, output register empty.
// ----------------------------------------------------------------------------
// ascii_sentence_validator
// Frames '$'-started sentences, checks length, XOR checksum, header and
// token count, and emits one verdict beat per sentence.
// ----------------------------------------------------------------------------
module ascii_sentence_validator (
    input  logic        aclk,
    input  logic        aresetn,
    // input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] rx_byte
    // verdict stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // [1:0] status, [9:2] body_length,
                                   // [17:10] computed_sum, [18] overflowed, rest zero
    // configuration
    input  logic        cfg_wr_en,
    input  logic        cfg_addr,
    input  logic [7:0]  cfg_wdata
);

    logic [7:0] min_length_reg;
    logic [6:0] expected_fields_reg;

    logic                    collecting_reg, collecting_next;
    logic [asv_pkg::CNT_W-1:0] byte_count_reg, byte_count_next;
    logic [7:0]              tail_reg [3];
    logic [7:0]              tail_next [3];
    logic [7:0]              prefix_xor_reg, prefix_xor_next;
    logic [7:0]              comma_count_reg, comma_count_next;
    logic                    header_match_reg, header_match_next;

    logic                    out_valid_reg;
    asv_pkg::verdict_t       out_reg;

    logic                    in_fire;
    logic                    emit;
    logic                    ovf;
    logic [asv_pkg::CNT_W-1:0] pos;
    logic [7:0]              old_byte;
    asv_pkg::verdict_t       verdict;
    asv_pkg::status_t        status;

    assign in_fire  = s_tvalid & s_tready;
    assign s_tready = ~out_valid_reg | m_tready;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {5'd0, out_reg};

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            min_length_reg      <= asv_pkg::MIN_LENGTH_RST;
            expected_fields_reg <= asv_pkg::EXPECTED_FIELDS_RST;
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                asv_pkg::CFG_MIN_LENGTH:      min_length_reg      <= cfg_wdata;
                asv_pkg::CFG_EXPECTED_FIELDS: expected_fields_reg <= cfg_wdata[6:0];
                default: ;
            endcase
        end
    end

    // per-byte state update
    always_comb begin
        collecting_next   = collecting_reg;
        byte_count_next   = byte_count_reg;
        tail_next         = tail_reg;
        prefix_xor_next   = prefix_xor_reg;
        comma_count_next  = comma_count_reg;
        header_match_next = header_match_reg;
        emit              = 1'b0;
        ovf               = 1'b0;
        pos               = byte_count_reg - asv_pkg::CNT_W'(3);
        old_byte          = tail_reg[0];

        if (in_fire) begin
            if (!collecting_reg) begin
                if (s_tdata == asv_pkg::START_CHAR) begin
                    collecting_next   = 1'b1;
                    byte_count_next   = '0;
                    tail_next         = '{8'd0, 8'd0, 8'd0};
                    prefix_xor_next   = 8'd0;
                    comma_count_next  = 8'd0;
                    header_match_next = 1'b1;
                end
            end else if (s_tdata == asv_pkg::CR_CHAR) begin
                emit            = 1'b1;
                collecting_next = 1'b0;
            end else begin
                // byte leaving the three-byte window joins the prefix
                if (byte_count_reg >= asv_pkg::CNT_W'(3)) begin
                    prefix_xor_next = prefix_xor_reg ^ old_byte;
                    if (old_byte == asv_pkg::COMMA_CHAR) begin
                        comma_count_next = comma_count_reg + 8'd1;
                    end
                    if (pos < asv_pkg::CNT_W'(asv_pkg::HDR_LEN)) begin
                        if (old_byte != asv_pkg::HDR_TEXT[pos[2:0]]) begin
                            header_match_next = 1'b0;
                        end
                    end else if (pos == asv_pkg::CNT_W'(asv_pkg::HDR_LEN)) begin
                        if (old_byte != asv_pkg::COMMA_CHAR) begin
                            header_match_next = 1'b0;
                        end
                    end
                end
                tail_next[0]    = tail_reg[1];
                tail_next[1]    = tail_reg[2];
                tail_next[2]    = s_tdata;
                byte_count_next = byte_count_reg + asv_pkg::CNT_W'(1);
                if (byte_count_next >= asv_pkg::CNT_W'(asv_pkg::BODY_MAX)) begin
                    emit            = 1'b1;
                    ovf             = 1'b1;
                    collecting_next = 1'b0;
                end
            end
        end
    end

    // verdict from the updated body state
    always_comb begin
        if (byte_count_next < asv_pkg::CNT_W'(3) || byte_count_next < min_length_reg) begin
            status = asv_pkg::ST_TOO_SHORT;
        end else if (tail_next[1] != asv_pkg::hex_char(prefix_xor_next[7:4]) ||
                     tail_next[2] != asv_pkg::hex_char(prefix_xor_next[3:0])) begin
            status = asv_pkg::ST_CKSUM_BAD;
        end else if (!header_match_next || byte_count_next < asv_pkg::CNT_W'(8) ||
                     ({1'b0, comma_count_next} + 9'd1) != {2'b00, expected_fields_reg}) begin
            status = asv_pkg::ST_HEADER_BAD;
        end else begin
            status = asv_pkg::ST_VALID;
        end
        verdict.status       = status;
        verdict.body_length  = byte_count_next;
        verdict.computed_sum = prefix_xor_next;
        verdict.overflowed   = ovf;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            collecting_reg   <= 1'b0;
            byte_count_reg   <= '0;
            tail_reg         <= '{8'd0, 8'd0, 8'd0};
            prefix_xor_reg   <= 8'd0;
            comma_count_reg  <= 8'd0;
            header_match_reg <= 1'b1;
            out_valid_reg    <= 1'b0;
        end else begin
            collecting_reg   <= collecting_next;
            byte_count_reg   <= byte_count_next;
            tail_reg         <= tail_next;
            prefix_xor_reg   <= prefix_xor_next;
            comma_count_reg  <= comma_count_next;
            header_match_reg <= header_match_next;
            if (emit) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // result payload
    always_ff @(posedge aclk) begin
        if (emit) begin
            out_reg <= verdict;
        end
    end

    // checks
    a_ovf_len: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && out_reg.overflowed |-> out_reg.body_length == 8'd255)
        else $error("overflow verdict without full body");

    a_short: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && out_reg.body_length < 8'd3 |-> out_reg.status == asv_pkg::ST_TOO_SHORT)
        else $error("body under three bytes not reported too short");

    a_prefix_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        byte_count_reg <= asv_pkg::CNT_W'(3) |-> prefix_xor_reg == 8'd0)
        else $error("prefix xor set before window filled");

    a_cr_verdict: assert property (@(posedge aclk) disable iff (!aresetn)
        in_fire && collecting_reg && s_tdata == asv_pkg::CR_CHAR |=> m_tvalid && !collecting_reg)
        else $error("end of sentence gave no verdict");

    a_hdr_fall: assert property (@(posedge aclk) disable iff (!aresetn)
        $fell(header_match_reg) |-> $past(collecting_reg))
        else $error("header flag cleared while hunting");

endmodule

[bench/tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for ascii_sentence_validator
// Feeds framed and broken sentences byte by byte, predicts each verdict from
// its own copy of the block state and compares every verdict beat field by field.
// ----------------------------------------------------------------------------
module tb;

    localparam int         CYCLE_LIMIT = 400_000;
    localparam logic [7:0] STAR_CHAR   = 8'h2A;

    typedef logic [7:0] byte_q_t [$];
    typedef enum int {FLAW_NONE, FLAW_SUM, FLAW_LOWER, FLAW_MARK} flaw_t;

    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata   = 8'd0;
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [23:0] m_tdata;
    logic        cfg_wr_en = 1'b0;
    logic        cfg_addr  = 1'b0;
    logic [7:0]  cfg_wdata = 8'd0;

    logic        steady    = 1'b0;  // no idling on either side while set
    int          cycles    = 0;
    int          errors    = 0;
    int          useful_bytes  = 0;
    int          verdicts_made = 0;

    // predicted block state
    logic       in_body     = 1'b0;
    logic [7:0] body_cnt    = 8'd0;
    logic [7:0] win [3]     = '{8'd0, 8'd0, 8'd0};
    logic [7:0] run_xor     = 8'd0;
    logic [7:0] comma_cnt   = 8'd0;
    logic       hdr_ok      = 1'b1;
    logic [7:0] min_len_cfg = asv_pkg::MIN_LENGTH_RST;
    logic [6:0] fields_cfg  = asv_pkg::EXPECTED_FIELDS_RST;

    asv_pkg::verdict_t verdicts_due [$];

    ascii_sentence_validator dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    initial begin
        forever #10 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    always @(posedge aclk) begin
        m_tready <= steady || ($urandom_range(0, 99) >= 28);
    end

    function automatic logic [7:0] hex_digit(input logic [3:0] n);
        return (n < 4'd10) ? (8'h30 + {4'd0, n}) : (8'h37 + {4'd0, n});
    endfunction

    function automatic logic [7:0] fold_xor(input byte_q_t q);
        logic [7:0] x;
        x = 8'd0;
        foreach (q[i]) x ^= q[i];
        return x;
    endfunction

    function automatic byte_q_t text_bytes(input string s);
        byte_q_t q;
        for (int i = 0; i < s.len(); i++) q.push_back(s[i]);
        return q;
    endfunction

    function automatic logic [7:0] rand_body_byte();
        logic [7:0] b;
        do b = 8'($urandom_range(0, 255)); while (b == asv_pkg::CR_CHAR);
        return b;
    endfunction

    // header token plus (tokens-1) comma separated fields
    function automatic byte_q_t make_prefix(input int tokens, input bit hdr_good,
                                            input int max_tok);
        byte_q_t    p;
        string      alphabet;
        logic [7:0] c;
        int         k;
        alphabet = "0123456789.-+";
        p = text_bytes("VNCMV");
        if (!hdr_good) begin
            if ($urandom_range(0, 1) == 0) begin
                k = $urandom_range(0, 4);
                p[k] = p[k] ^ 8'h20;
            end else begin
                p.push_back("X");  // header token too long
            end
        end
        for (int t = 1; t < tokens; t++) begin
            p.push_back(asv_pkg::COMMA_CHAR);
            k = $urandom_range(0, max_tok);
            repeat (k) begin
                if ($urandom_range(0, 9) == 0) begin
                    do c = rand_body_byte(); while (c == asv_pkg::COMMA_CHAR);
                end else begin
                    c = alphabet[$urandom_range(0, alphabet.len() - 1)];
                end
                p.push_back(c);
            end
        end
        return p;
    endfunction

    task automatic note_mismatch(input string what, input int want, input int got);
        errors++;
        if (errors <= 10) begin
            $display("mismatch %s: expected %0d, got %0d (t=%0t)", what, want, got, $realtime);
        end
    endtask

    task automatic post_verdict(input logic ovf);
        asv_pkg::verdict_t v;
        if (body_cnt < 8'd3 || body_cnt < min_len_cfg) begin
            v.status = asv_pkg::ST_TOO_SHORT;
        end else if (win[1] != hex_digit(run_xor[7:4]) || win[2] != hex_digit(run_xor[3:0])) begin
            v.status = asv_pkg::ST_CKSUM_BAD;
        end else if (!hdr_ok || body_cnt < 8'd8 ||
                     ({1'b0, comma_cnt} + 9'd1) != {2'b00, fields_cfg}) begin
            v.status = asv_pkg::ST_HEADER_BAD;
        end else begin
            v.status = asv_pkg::ST_VALID;
        end
        v.body_length  = body_cnt;
        v.computed_sum = run_xor;
        v.overflowed   = ovf;
        verdicts_due.push_back(v);
        verdicts_made++;
        in_body = 1'b0;
    endtask

    // advance the predicted state by one accepted byte
    task automatic absorb_byte(input logic [7:0] b);
        logic [7:0] old;
        logic [7:0] pos;
        logic [7:0] hdr_char;
        if (!in_body) begin
            if (b == asv_pkg::START_CHAR) begin
                useful_bytes++;
                in_body   = 1'b1;
                body_cnt  = 8'd0;
                win       = '{8'd0, 8'd0, 8'd0};
                run_xor   = 8'd0;
                comma_cnt = 8'd0;
                hdr_ok    = 1'b1;
            end
        end else if (b == asv_pkg::CR_CHAR) begin
            useful_bytes++;
            post_verdict(1'b0);
        end else begin
            useful_bytes++;
            if (body_cnt >= 8'd3) begin
                // byte leaving the three-byte window joins the prefix
                pos = body_cnt - 8'd3;
                old = win[0];
                run_xor ^= old;
                if (old == asv_pkg::COMMA_CHAR) comma_cnt = comma_cnt + 8'd1;
                if (pos < asv_pkg::HDR_LEN) begin
                    hdr_char = asv_pkg::HDR_TEXT[pos];
                    if (old != hdr_char) hdr_ok = 1'b0;
                end else if (pos == asv_pkg::HDR_LEN) begin
                    if (old != asv_pkg::COMMA_CHAR) hdr_ok = 1'b0;
                end
            end
            win[0]   = win[1];
            win[1]   = win[2];
            win[2]   = b;
            body_cnt = body_cnt + 8'd1;
            if (body_cnt >= asv_pkg::BODY_MAX) post_verdict(1'b1);
        end
    endtask

    always @(posedge aclk) begin : verdict_check
        asv_pkg::verdict_t got;
        asv_pkg::verdict_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got = asv_pkg::verdict_t'(m_tdata[18:0]);
            if (verdicts_due.size() == 0) begin
                note_mismatch("unexpected verdict beat", 0, int'(m_tdata));
            end else begin
                want = verdicts_due.pop_front();
                if (got.status !== want.status)
                    note_mismatch("status", want.status, got.status);
                if (got.body_length !== want.body_length)
                    note_mismatch("body_length", want.body_length, got.body_length);
                if (got.computed_sum !== want.computed_sum)
                    note_mismatch("computed_sum", want.computed_sum, got.computed_sum);
                if (got.overflowed !== want.overflowed)
                    note_mismatch("overflowed", want.overflowed, got.overflowed);
                if (m_tdata[23:19] !== 5'd0)
                    note_mismatch("pad bits", 0, int'(m_tdata[23:19]));
            end
        end
    end

    task automatic send_byte(input logic [7:0] b);
        while (!steady && $urandom_range(0, 99) < 28) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        absorb_byte(b);
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (verdicts_due.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_cfg(input logic addr, input logic [7:0] val);
        wait_drained();
        cfg_wr_en <= 1'b1;
        cfg_addr  <= addr;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        if (addr == asv_pkg::CFG_MIN_LENGTH) min_len_cfg = val;
        else fields_cfg = val[6:0];
    endtask

    task automatic close_open_body();
        if (in_body) send_byte(asv_pkg::CR_CHAR);
    endtask

    task automatic send_noise(input int n, input bit allow_start);
        logic [7:0] b;
        repeat (n) begin
            do b = 8'($urandom_range(0, 255));
            while (!allow_start && b == asv_pkg::START_CHAR);
            send_byte(b);
        end
    endtask

    // '$' + prefix + mark + two hex digits + CR
    task automatic send_sentence(input byte_q_t prefix, input flaw_t flaw);
        logic [7:0] x;
        logic [7:0] mark;
        logic [7:0] hi;
        logic [7:0] lo;
        x    = fold_xor(prefix);
        mark = STAR_CHAR;
        hi   = hex_digit(x[7:4]);
        lo   = hex_digit(x[3:0]);
        case (flaw)
            FLAW_SUM: begin
                lo = hex_digit(x[3:0] ^ 4'($urandom_range(1, 15)));
            end
            FLAW_LOWER: begin
                if (hi >= "A") hi = hi | 8'h20;
                if (lo >= "A") lo = lo | 8'h20;
            end
            FLAW_MARK: begin
                mark = rand_body_byte();
            end
            default: ;
        endcase
        close_open_body();
        send_byte(asv_pkg::START_CHAR);
        foreach (prefix[i]) send_byte(prefix[i]);
        send_byte(mark);
        send_byte(hi);
        send_byte(lo);
        send_byte(asv_pkg::CR_CHAR);
    endtask

    task automatic test_reset_defaults();
        send_noise(6, 1'b0);
        send_byte(8'h00);
        send_byte(8'hFF);
        send_sentence(make_prefix(11, 1'b1, 1), FLAW_NONE);
        send_sentence(make_prefix(10, 1'b1, 1), FLAW_NONE);
        send_sentence(make_prefix(1, 1'b1, 0), FLAW_NONE);  // 8 bytes, below default 9
    endtask

    task automatic test_short_bodies();
        write_cfg(asv_pkg::CFG_MIN_LENGTH, 8'd0);
        send_byte(asv_pkg::START_CHAR);
        send_byte(asv_pkg::CR_CHAR);
        send_byte(asv_pkg::START_CHAR);
        send_byte("A");
        send_byte(asv_pkg::CR_CHAR);
        send_byte(asv_pkg::START_CHAR);
        send_byte("A");
        send_byte("B");
        send_byte(asv_pkg::CR_CHAR);
        send_sentence(text_bytes(""), FLAW_NONE);     // "*00" only
        send_sentence(text_bytes("VN"), FLAW_NONE);
        write_cfg(asv_pkg::CFG_MIN_LENGTH, 8'd3);
        send_sentence(text_bytes("VNCM"), FLAW_NONE);
        send_sentence(text_bytes("VNCMV"), FLAW_NONE);
    endtask

    task automatic test_checksum_cases();
        byte_q_t p;
        send_sentence(make_prefix(11, 1'b1, 1), FLAW_SUM);
        send_sentence(make_prefix(11, 1'b1, 1), FLAW_MARK);
        do p = make_prefix(11, 1'b1, 1); while (fold_xor(p) < 8'hA0);
        send_sentence(p, FLAW_LOWER);
        send_sentence(make_prefix(11, 1'b0, 1), FLAW_SUM);   // checksum wins over header
        send_sentence(make_prefix(11, 1'b0, 1), FLAW_NONE);
        write_cfg(asv_pkg::CFG_MIN_LENGTH, 8'd255);
        send_sentence(make_prefix(11, 1'b1, 1), FLAW_SUM);   // length wins over checksum
        write_cfg(asv_pkg::CFG_MIN_LENGTH, 8'd3);
    endtask

    task automatic test_field_limits();
        byte_q_t p;
        write_cfg(asv_pkg::CFG_EXPECTED_FIELDS, 8'd1);
        send_sentence(make_prefix(1, 1'b1, 0), FLAW_NONE);
        send_sentence(make_prefix(2, 1'b1, 0), FLAW_NONE);
        write_cfg(asv_pkg::CFG_EXPECTED_FIELDS, 8'd64);
        send_sentence(make_prefix(64, 1'b1, 0), FLAW_NONE);
        write_cfg(asv_pkg::CFG_EXPECTED_FIELDS, 8'd0);
        send_sentence(make_prefix(1, 1'b1, 0), FLAW_NONE);
        // start marks and zero bytes inside a body are plain data
        write_cfg(asv_pkg::CFG_EXPECTED_FIELDS, 8'd4);
        p = text_bytes("VNCMV,$,");
        p.push_back(8'h00);
        p.push_back(asv_pkg::COMMA_CHAR);
        p.push_back(asv_pkg::START_CHAR);
        p.push_back(8'h00);
        send_sentence(p, FLAW_NONE);
    endtask

    task automatic test_overflow();
        byte_q_t p;
        write_cfg(asv_pkg::CFG_EXPECTED_FIELDS, 8'd11);
        write_cfg(asv_pkg::CFG_MIN_LENGTH, 8'd255);
        // 252 + 3 tail bytes: verdict lands on the last hex digit, CR is dropped
        p = make_prefix(11, 1'b1, 2);
        while (p.size() < 252) p.push_back("7");
        send_sentence(p, FLAW_NONE);
        write_cfg(asv_pkg::CFG_MIN_LENGTH, 8'd9);
    endtask

    task automatic test_random_traffic();
        byte_q_t p;
        flaw_t   flaw;
        int      round;
        int      pick;
        int      toks;
        int      max_tok;
        int      bytes_goal;
        int      verdict_goal;
        bytes_goal   = useful_bytes + 120;
        verdict_goal = verdicts_made + 6;
        round        = 0;
        steady      <= 1'b1;
        while (useful_bytes < bytes_goal || verdicts_made < verdict_goal) begin
            round++;
            if (round == 4) steady <= 1'b0;
            if (round % 4 == 0) begin
                pick = $urandom_range(0, 9);
                write_cfg(asv_pkg::CFG_MIN_LENGTH, (pick == 0) ? 8'd3 :
                          (pick == 1) ? 8'd255 : 8'($urandom_range(3, 40)));
                pick = $urandom_range(0, 9);
                write_cfg(asv_pkg::CFG_EXPECTED_FIELDS, (pick == 0) ? 8'd1 :
                          (pick == 1) ? 8'd64 :
                          (pick == 2) ? (8'($urandom_range(1, 14)) | 8'h80) :
                          8'($urandom_range(1, 14)));
            end
            pick = $urandom_range(0, 99);
            max_tok = (fields_cfg > 7'd20) ? 1 : $urandom_range(0, 2);
            if (fields_cfg != 7'd0 && $urandom_range(0, 2) != 0) toks = fields_cfg;
            else toks = $urandom_range(1, int'(fields_cfg) + 2);
            if (pick < 62) begin
                pick = $urandom_range(0, 99);
                flaw = (pick < 70) ? FLAW_NONE : (pick < 80) ? FLAW_SUM :
                       (pick < 88) ? FLAW_LOWER : FLAW_MARK;
                p = make_prefix(toks, $urandom_range(0, 19) != 0, max_tok);
                send_sentence(p, flaw);
            end else if (pick < 74) begin
                send_noise($urandom_range(1, 12), 1'b1);
            end else if (pick < 87) begin
                close_open_body();
                send_byte(asv_pkg::START_CHAR);
                repeat ($urandom_range(0, 20)) send_byte(rand_body_byte());
                send_byte(asv_pkg::CR_CHAR);
            end else begin
                // tail missing: body ends right after the fields
                close_open_body();
                p = make_prefix(toks, 1'b1, max_tok);
                send_byte(asv_pkg::START_CHAR);
                foreach (p[i]) send_byte(p[i]);
                send_byte(asv_pkg::CR_CHAR);
            end
        end
    endtask

    initial begin
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_reset_defaults();
        test_short_bodies();
        test_checksum_cases();
        test_field_limits();
        test_overflow();
        test_random_traffic();
        wait_drained();
        repeat (8) @(posedge aclk);
        if (errors == 0 && verdicts_due.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
